>>> hdl/vrm_pkg.sv
package vrm_pkg;

  localparam int unsigned MAX_STEPS_DEF = 64;

  localparam int unsigned DIV_NW = 64;  // dividend / quotient width
  localparam int unsigned DIV_DW = 32;  // divisor / remainder width

  // t values: 48-bit saturating Q32.16 plus one code above the cap for "never"
  localparam int unsigned TW = 49;
  localparam logic [TW-1:0] T_CAP = {1'b0, {(TW-1){1'b1}}};
  localparam logic [TW-1:0] T_INF = {1'b1, {(TW-1){1'b0}}};

  localparam logic [1:0] LAST_AXIS = 2'd2;

  // datapath operations
  localparam logic [3:0] OP_IDLE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_DIVC  = 4'd2;
  localparam logic [3:0] OP_CELL  = 4'd3;
  localparam logic [3:0] OP_MUL   = 4'd4;
  localparam logic [3:0] OP_DIST  = 4'd5;
  localparam logic [3:0] OP_DIVT  = 4'd6;
  localparam logic [3:0] OP_DIVD  = 4'd7;
  localparam logic [3:0] OP_MARCH = 4'd8;

  // config register indexes
  localparam logic [1:0] REG_GX   = 2'd0;
  localparam logic [1:0] REG_GY   = 2'd1;
  localparam logic [1:0] REG_GZ   = 2'd2;
  localparam logic [1:0] REG_EDGE = 2'd3;

  typedef struct packed {
    logic [3:0] op;
    logic       div_go;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic dir_zero;
    logic march_end;
  } sts_t;

endpackage

>>> hdl/voxel_ray_march_3d.sv
// Channel   Handshake                      Payload
// --------  -----------------------------  ----------------------------------------
// request   start & !busy                  in_ray_origin_x/y/z, in_ray_dir_x/y/z,
//                                          in_max_distance
// result    out_valid (one cycle, no stall) out_cell_x/y/z, out_last, out_capped
// config    APB write: psel&penable&pwrite grid origin x/y/z, cell edge (4*i)
//
// Setup shares one radix-2 divider; each divide is go, one bit step per quotient bit,
// done. Per axis: start-cell divide, then the CELL, MUL and DIST states, then the t_max
// and t_delta divides (skipped for a zero direction component). Then one cell per cycle,
// up to MAX_STEPS cells, each registered and shown in the next cycle.
// Reset (rst_n low, synchronous) returns to idle and restores register defaults.
// The receiver cannot stall; busy stays high from acceptance to the final march step.
module voxel_ray_march_3d #(
  parameter int unsigned MAX_STEPS = vrm_pkg::MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_ray_origin_x,
  input  logic signed [31:0] in_ray_origin_y,
  input  logic signed [31:0] in_ray_origin_z,
  input  logic signed [17:0] in_ray_dir_x,
  input  logic signed [17:0] in_ray_dir_y,
  input  logic signed [17:0] in_ray_dir_z,
  input  logic [30:0]        in_max_distance,
  // results
  output logic               out_valid,
  output logic signed [31:0] out_cell_x,
  output logic signed [31:0] out_cell_y,
  output logic signed [31:0] out_cell_z,
  output logic               out_last,
  output logic               out_capped,
  // config (APB)
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [31:0] cfg_gx_r, cfg_gy_r, cfg_gz_r;
  logic [30:0]        cfg_edge_r;
  logic               wr_en;

  vrm_pkg::cmd_t cmd;
  vrm_pkg::sts_t sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register file, word index from paddr[3:2]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_gx_r   <= '0;
      cfg_gy_r   <= '0;
      cfg_gz_r   <= '0;
      cfg_edge_r <= 31'd65536;
    end else if (wr_en) begin
      case (paddr[3:2])
        vrm_pkg::REG_GX: cfg_gx_r   <= pwdata;
        vrm_pkg::REG_GY: cfg_gy_r   <= pwdata;
        vrm_pkg::REG_GZ: cfg_gz_r   <= pwdata;
        default:         cfg_edge_r <= pwdata[30:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      vrm_pkg::REG_GX: prdata = cfg_gx_r;
      vrm_pkg::REG_GY: prdata = cfg_gy_r;
      vrm_pkg::REG_GZ: prdata = cfg_gz_r;
      default:         prdata = {1'b0, cfg_edge_r};
    endcase
  end

  // sequencer: setup per axis, then march
  vrm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // divider, multiplier, per-axis t state, cell stepping
  vrm_dp #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .grid_x       (cfg_gx_r),
    .grid_y       (cfg_gy_r),
    .grid_z       (cfg_gz_r),
    .edge_len     (cfg_edge_r),
    .ray_origin_x (in_ray_origin_x),
    .ray_origin_y (in_ray_origin_y),
    .ray_origin_z (in_ray_origin_z),
    .ray_dir_x    (in_ray_dir_x),
    .ray_dir_y    (in_ray_dir_y),
    .ray_dir_z    (in_ray_dir_z),
    .ray_max_t    (in_max_distance),
    .out_valid    (out_valid),
    .cell_x       (out_cell_x),
    .cell_y       (out_cell_y),
    .cell_z       (out_cell_z),
    .last         (out_last),
    .capped       (out_capped)
  );

endmodule

>>> hdl/vrm_div.sv
module vrm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [vrm_pkg::DIV_NW-1:0]    dvd,
  input  logic [vrm_pkg::DIV_DW-1:0]    dvs,
  output logic [vrm_pkg::DIV_NW-1:0]    quo,
  output logic [vrm_pkg::DIV_DW-1:0]    rem,
  output logic                          done
);

  localparam int unsigned CW = $clog2(vrm_pkg::DIV_NW);

  logic                        run_r;
  logic                        done_r;
  logic [CW-1:0]               cnt_r;
  logic [vrm_pkg::DIV_NW-1:0]  quo_r;
  logic [vrm_pkg::DIV_DW:0]    rem_r;
  logic [vrm_pkg::DIV_DW-1:0]  dvs_r;

  logic [vrm_pkg::DIV_DW:0]    rem_sh;
  logic [vrm_pkg::DIV_DW:0]    trial;

  // restoring, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_r[vrm_pkg::DIV_DW-1:0], quo_r[vrm_pkg::DIV_NW-1]};
    trial  = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(vrm_pkg::DIV_NW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dvd;
      rem_r <= '0;
      dvs_r <= dvs;
    end else if (run_r) begin
      if (!trial[vrm_pkg::DIV_DW]) begin
        rem_r <= trial;
        quo_r <= {quo_r[vrm_pkg::DIV_NW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[vrm_pkg::DIV_NW-2:0], 1'b0};
      end
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r[vrm_pkg::DIV_DW-1:0];
  assign done = done_r;

endmodule

>>> hdl/vrm_dp.sv
module vrm_dp #(
  parameter int unsigned MAX_STEPS = vrm_pkg::MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vrm_pkg::cmd_t      cmd,
  output vrm_pkg::sts_t      sts,
  input  logic signed [31:0] grid_x,
  input  logic signed [31:0] grid_y,
  input  logic signed [31:0] grid_z,
  input  logic [30:0]        edge_len,
  input  logic signed [31:0] ray_origin_x,
  input  logic signed [31:0] ray_origin_y,
  input  logic signed [31:0] ray_origin_z,
  input  logic signed [17:0] ray_dir_x,
  input  logic signed [17:0] ray_dir_y,
  input  logic signed [17:0] ray_dir_z,
  input  logic [30:0]        ray_max_t,
  output logic               out_valid,
  output logic signed [31:0] cell_x,
  output logic signed [31:0] cell_y,
  output logic signed [31:0] cell_z,
  output logic               last,
  output logic               capped
);

  localparam int unsigned NW = $clog2(MAX_STEPS + 1);
  localparam int unsigned TW = vrm_pkg::TW;
  localparam logic signed [31:0] I32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] I32_MIN = 32'sh80000000;

  logic signed [31:0] org_r [3];
  logic signed [17:0] dir_r [3];
  logic [30:0]        maxd_r;
  logic signed [31:0] c_r [3];
  logic [TW-1:0]      tmax_r [3];
  logic [TW-1:0]      tdel_r [3];
  logic [2:0]         snz_r;
  logic [2:0]         sneg_r;
  logic signed [64:0] prod_r;
  logic [46:0]        num_r;
  logic               big_r;
  logic [NW-1:0]      n_r;

  logic               ov_r;
  logic signed [31:0] ocx_r, ocy_r, ocz_r;
  logic               olast_r, ocap_r;

  // per-axis selection
  logic [30:0]        e;
  logic signed [31:0] p_s, g_s, c_s;
  logic signed [17:0] d_s;
  logic               pos;
  logic [17:0]        ad;
  logic signed [32:0] dd;
  logic [32:0]        dmag;

  logic [63:0]        dvd;
  logic [31:0]        dvs;
  logic [63:0]        quo;
  logic [31:0]        rem;
  logic               ddone;
  logic [TW-1:0]      qsat;

  logic signed [33:0] qf;
  logic signed [31:0] cnew;
  logic signed [32:0] cinc;
  logic signed [65:0] bnd, span_d;

  // march step
  logic [1:0]         ax;
  logic [TW-1:0]      t_s, td_s;
  logic [TW:0]        tsum;
  logic [TW-1:0]      tnext;
  logic               far, cap_hit, m_last, m_cap;
  logic signed [31:0] cstep;

  assign e = (edge_len == '0) ? 31'd1 : edge_len;

  always_comb begin
    case (cmd.axis)
      2'd0:    begin g_s = grid_x; end
      2'd1:    begin g_s = grid_y; end
      default: begin g_s = grid_z; end
    endcase
  end

  assign p_s  = org_r[cmd.axis];
  assign c_s  = c_r[cmd.axis];
  assign d_s  = dir_r[cmd.axis];
  assign pos  = !d_s[17] && (d_s != '0);
  assign ad   = d_s[17] ? 18'(-d_s) : 18'(d_s);
  assign dd   = {p_s[31], p_s} - {g_s[31], g_s};
  assign dmag = dd[32] ? 33'(-dd) : 33'(dd);

  always_comb begin
    case (cmd.op)
      vrm_pkg::OP_DIVC: begin
        dvd = {31'd0, dmag};
        dvs = {1'b0, e};
      end
      vrm_pkg::OP_DIVT: begin
        dvd = {1'b0, num_r, 16'd0};
        dvs = {14'd0, ad};
      end
      default: begin
        dvd = {17'd0, e, 16'd0};
        dvs = {14'd0, ad};
      end
    endcase
  end

  vrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.div_go),
    .dvd   (dvd),
    .dvs   (dvs),
    .quo   (quo),
    .rem   (rem),
    .done  (ddone)
  );

  assign qsat = (quo[63:48] != '0) ? vrm_pkg::T_CAP : {1'b0, quo[47:0]};

  // floor of signed division, then clamp to int32
  always_comb begin
    qf = {1'b0, quo[32:0]};
    if (dd[32]) qf = -(qf + 34'(rem != '0));
    if (qf > 34'sd2147483647)        cnew = I32_MAX;
    else if (qf < -34'sd2147483648)  cnew = I32_MIN;
    else                             cnew = qf[31:0];
  end

  assign cinc   = {c_s[31], c_s} + 33'(pos);
  assign bnd    = 66'(g_s) + 66'(prod_r);
  assign span_d = pos ? (bnd - 66'(p_s)) : (66'(p_s) - bnd);

  // axis with the smallest t_max, ties go to the later axis (z over y over x)
  always_comb begin
    if (tmax_r[0] < tmax_r[1]) ax = (tmax_r[0] < tmax_r[2]) ? 2'd0 : 2'd2;
    else                       ax = (tmax_r[1] < tmax_r[2]) ? 2'd1 : 2'd2;
  end

  assign t_s     = tmax_r[ax];
  assign td_s    = tdel_r[ax];
  assign tsum    = {1'b0, t_s} + {1'b0, td_s};
  assign tnext   = (t_s[TW-1] || td_s[TW-1]) ? vrm_pkg::T_INF :
                   (tsum > {1'b0, vrm_pkg::T_CAP}) ? vrm_pkg::T_CAP : tsum[TW-1:0];
  assign far     = t_s > {18'd0, maxd_r};
  assign cap_hit = ({1'b0, n_r} + 1'b1) >= (NW + 1)'(MAX_STEPS);
  assign m_last  = !snz_r[ax] || far || cap_hit;
  assign m_cap   = snz_r[ax] && !far && cap_hit;

  always_comb begin
    cstep = c_r[ax];
    if (sneg_r[ax]) begin
      if (c_r[ax] != I32_MIN) cstep = c_r[ax] - 32'sd1;
    end else begin
      if (c_r[ax] != I32_MAX) cstep = c_r[ax] + 32'sd1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      vrm_pkg::OP_LOAD: begin
        org_r[0] <= ray_origin_x;
        org_r[1] <= ray_origin_y;
        org_r[2] <= ray_origin_z;
        dir_r[0] <= ray_dir_x;
        dir_r[1] <= ray_dir_y;
        dir_r[2] <= ray_dir_z;
        maxd_r   <= ray_max_t;
        n_r      <= '0;
      end
      vrm_pkg::OP_CELL: c_r[cmd.axis] <= cnew;
      vrm_pkg::OP_MUL:  prod_r <= cinc * $signed({2'b0, e});
      vrm_pkg::OP_DIST: begin
        num_r <= (span_d[65] || span_d[65:47] != '0) ? '0 : span_d[46:0];
        big_r <= !span_d[65] && (span_d[65:47] != '0);
        snz_r[cmd.axis]  <= (d_s != '0);
        sneg_r[cmd.axis] <= d_s[17];
        if (d_s == '0) begin
          tmax_r[cmd.axis] <= vrm_pkg::T_INF;
          tdel_r[cmd.axis] <= vrm_pkg::T_INF;
        end
      end
      vrm_pkg::OP_DIVT: if (ddone) tmax_r[cmd.axis] <= big_r ? vrm_pkg::T_CAP : qsat;
      vrm_pkg::OP_DIVD: if (ddone) tdel_r[cmd.axis] <= qsat;
      vrm_pkg::OP_MARCH: begin
        ocx_r   <= c_r[0];
        ocy_r   <= c_r[1];
        ocz_r   <= c_r[2];
        olast_r <= m_last;
        ocap_r  <= m_cap;
        n_r     <= n_r + 1'b1;
        if (snz_r[ax]) begin
          c_r[ax]    <= cstep;
          tmax_r[ax] <= tnext;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= (cmd.op == vrm_pkg::OP_MARCH);
  end

  assign sts.div_done  = ddone;
  assign sts.dir_zero  = (d_s == '0);
  assign sts.march_end = (cmd.op == vrm_pkg::OP_MARCH) && m_last;

  assign out_valid = ov_r;
  assign cell_x    = ocx_r;
  assign cell_y    = ocy_r;
  assign cell_z    = ocz_r;
  assign last      = olast_r;
  assign capped    = ocap_r;

endmodule

>>> hdl/vrm_ctrl.sv
module vrm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output vrm_pkg::cmd_t cmd,
  input  vrm_pkg::sts_t sts
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIVC_G = 4'd1;
  localparam logic [3:0] S_DIVC_W = 4'd2;
  localparam logic [3:0] S_CELL   = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_DIST   = 4'd5;
  localparam logic [3:0] S_DIVT_G = 4'd6;
  localparam logic [3:0] S_DIVT_W = 4'd7;
  localparam logic [3:0] S_DIVD_G = 4'd8;
  localparam logic [3:0] S_DIVD_W = 4'd9;
  localparam logic [3:0] S_MARCH  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;

  always_comb begin
    state_nxt  = state_r;
    axis_nxt   = axis_r;
    cmd.op     = vrm_pkg::OP_IDLE;
    cmd.div_go = 1'b0;
    cmd.axis   = axis_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = vrm_pkg::OP_LOAD;
          axis_nxt  = '0;
          state_nxt = S_DIVC_G;
        end
      end
      S_DIVC_G: begin
        cmd.op     = vrm_pkg::OP_DIVC;
        cmd.div_go = 1'b1;
        state_nxt  = S_DIVC_W;
      end
      S_DIVC_W: begin
        cmd.op = vrm_pkg::OP_DIVC;
        if (sts.div_done) state_nxt = S_CELL;
      end
      S_CELL: begin
        cmd.op    = vrm_pkg::OP_CELL;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = vrm_pkg::OP_MUL;
        state_nxt = S_DIST;
      end
      S_DIST: begin
        cmd.op = vrm_pkg::OP_DIST;
        if (!sts.dir_zero) state_nxt = S_DIVT_G;
        else if (axis_r == vrm_pkg::LAST_AXIS) state_nxt = S_MARCH;
        else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_DIVC_G;
        end
      end
      S_DIVT_G: begin
        cmd.op     = vrm_pkg::OP_DIVT;
        cmd.div_go = 1'b1;
        state_nxt  = S_DIVT_W;
      end
      S_DIVT_W: begin
        cmd.op = vrm_pkg::OP_DIVT;
        if (sts.div_done) state_nxt = S_DIVD_G;
      end
      S_DIVD_G: begin
        cmd.op     = vrm_pkg::OP_DIVD;
        cmd.div_go = 1'b1;
        state_nxt  = S_DIVD_W;
      end
      S_DIVD_W: begin
        cmd.op = vrm_pkg::OP_DIVD;
        if (sts.div_done) begin
          if (axis_r == vrm_pkg::LAST_AXIS) state_nxt = S_MARCH;
          else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = S_DIVC_G;
          end
        end
      end
      S_MARCH: begin
        cmd.op = vrm_pkg::OP_MARCH;
        if (sts.march_end) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DIVC_W || state_r == S_DIVT_W || state_r == S_DIVD_W))
    else $error("divider finished outside a wait state");

  a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> state_r == S_DIVC_G && axis_r == '0)
    else $error("accepted request did not begin setup");

  a_march_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARCH && sts.march_end) |=> state_r == S_IDLE)
    else $error("march did not end on final cell");

endmodule
